>>> rtl/core/nps_pkg.sv
// ----------------------------------------------------------------------------
// nps_pkg
// Shared types and constants for the non-preemptive priority scheduler.
// ----------------------------------------------------------------------------
`default_nettype none

package nps_pkg;

	localparam int unsigned OUT_TIME_W = 21;
	localparam int unsigned OUT_TAT_W  = 22;
	localparam int unsigned SUM_W      = 25;

	// one process record as loaded
	typedef struct packed {
		logic [7:0]  proc_id;
		logic [15:0] arrival;
		logic [15:0] burst;
		logic [7:0]  prio_level;
	} proc_rec_t;

	// classified load beat handed from front to back
	typedef struct packed {
		proc_rec_t rec;
		logic      store;
		logic      last;
	} load_beat_t;

endpackage

`default_nettype wire

>>> rtl/core/nps_front.sv
// ----------------------------------------------------------------------------
// nps_front
// Accepts process records and marks each one as stored or dropped (table
// full) and as closing the run.
// ----------------------------------------------------------------------------
`default_nettype none

module nps_front #(
	parameter int unsigned MAX_PROCS = 16
) (
	input  wire                      clk,
	input  wire                      arst_n,
	input  wire                      in_valid,
	output logic                     in_ready,
	input  wire  [7:0]               proc_id,
	input  wire  [15:0]              arrival,
	input  wire  [15:0]              burst,
	input  wire  [7:0]               prio_level,
	input  wire                      last_process,
	output logic                     beat_valid,
	input  wire                      beat_ready,
	output nps_pkg::load_beat_t      beat
);

	localparam int unsigned CW = $clog2(MAX_PROCS + 1);

	logic [CW-1:0] cnt_q;
	logic          store;
	logic          accept;

	assign store      = cnt_q < CW'(MAX_PROCS);
	assign in_ready   = beat_ready;
	assign beat_valid = in_valid;
	assign accept     = in_valid && beat_ready;

	always_comb begin
		beat.rec.proc_id    = proc_id;
		beat.rec.arrival    = arrival;
		beat.rec.burst      = burst;
		beat.rec.prio_level = prio_level;
		beat.store          = store;
		beat.last           = last_process;
	end

	// local fill count, restarts with each run
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cnt_q <= '0;
		end else if (accept) begin
			if (last_process) begin
				cnt_q <= '0;
			end else if (store) begin
				cnt_q <= cnt_q + CW'(1);
			end
		end
	end

endmodule

`default_nettype wire

>>> rtl/core/nps_queue.sv
// ----------------------------------------------------------------------------
// nps_queue
// Two-entry queue of load beats between front and back.
// ----------------------------------------------------------------------------
`default_nettype none

module nps_queue (
	input  wire                      clk,
	input  wire                      arst_n,
	input  wire                      wr_valid,
	output logic                     wr_ready,
	input  wire  nps_pkg::load_beat_t wr_beat,
	output logic                     rd_valid,
	input  wire                      rd_ready,
	output nps_pkg::load_beat_t      rd_beat
);

	nps_pkg::load_beat_t slot_q [2];
	logic       wr_ptr_q;
	logic       rd_ptr_q;
	logic [1:0] count_q;
	logic       push;
	logic       pop;

	assign wr_ready = count_q != 2'd2;
	assign rd_valid = count_q != 2'd0;
	assign rd_beat  = slot_q[rd_ptr_q];
	assign push     = wr_valid && wr_ready;
	assign pop      = rd_valid && rd_ready;

	always_ff @(posedge clk) begin
		if (push) begin
			slot_q[wr_ptr_q] <= wr_beat;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= 1'b0;
			rd_ptr_q <= 1'b0;
			count_q  <= 2'd0;
		end else begin
			if (push) wr_ptr_q <= ~wr_ptr_q;
			if (pop)  rd_ptr_q <= ~rd_ptr_q;
			if (push && !pop) begin
				count_q <= count_q + 2'd1;
			end else if (pop && !push) begin
				count_q <= count_q - 2'd1;
			end
		end
	end

endmodule

`default_nettype wire

>>> rtl/core/nps_back.sv
// ----------------------------------------------------------------------------
// nps_back
// Stores records, runs the priority schedule by repeated table scans and
// emits one result per stored record in load order.
// ----------------------------------------------------------------------------
`default_nettype none

module nps_back #(
	parameter int unsigned MAX_PROCS = 16
) (
	input  wire                       clk,
	input  wire                       arst_n,
	input  wire                       beat_valid,
	output logic                      beat_ready,
	input  wire  nps_pkg::load_beat_t beat,
	output logic                      out_valid,
	input  wire                       out_ready,
	output logic [7:0]                out_id,
	output logic [20:0]               start_time,
	output logic [20:0]               wait_time,
	output logic [21:0]               turnaround,
	output logic [24:0]               total_wait,
	output logic [24:0]               total_turnaround,
	output logic                      final_result
);

	localparam int unsigned CW = $clog2(MAX_PROCS + 1);
	localparam int unsigned IW = (MAX_PROCS > 1) ? $clog2(MAX_PROCS) : 1;
	localparam int unsigned TW = 16 + CW;
	localparam int unsigned SW = nps_pkg::SUM_W;

	typedef enum logic [5:0] {
		ST_IDLE     = 6'b000001,
		ST_SCAN     = 6'b000010,
		ST_DRAIN    = 6'b000100,
		ST_SEL      = 6'b001000,
		ST_EMIT_RD  = 6'b010000,
		ST_EMIT_OUT = 6'b100000
	} state_t;

	state_t state_q;

	nps_pkg::proc_rec_t proc_mem [MAX_PROCS];
	logic [TW-1:0]      start_mem [MAX_PROCS];

	logic [CW-1:0]        n_q;
	logic [CW-1:0]        left_q;
	logic [TW-1:0]        time_q;
	logic [MAX_PROCS-1:0] done_q;
	logic [IW-1:0]        scan_idx_q;
	logic [IW-1:0]        emit_idx_q;

	logic                 have_q;
	logic [IW-1:0]        best_idx_q;
	logic [7:0]           best_prio_q;
	logic [15:0]          best_arr_q;
	logic [15:0]          best_run_q;
	logic [15:0]          nxt_arr_q;

	logic                 v_s1;
	logic [IW-1:0]        idx_s1;
	nps_pkg::proc_rec_t   rec_s1;
	logic [TW-1:0]        start_s1;

	logic [SW-1:0]        sum_w_q;
	logic [SW-1:0]        sum_t_q;
	logic                 out_valid_q;

	logic [IW-1:0]        rd_addr;
	logic [IW-1:0]        last_idx;
	logic                 pop;
	logic [CW-1:0]        n_new;
	logic                 cand;
	logic                 arrived;
	logic                 better;
	logic                 out_load;
	logic [SW-1:0]        wait_x;
	logic [SW-1:0]        tat_x;

	assign beat_ready = state_q == ST_IDLE;
	assign pop        = beat_valid && beat_ready;
	assign n_new      = beat.store ? n_q + CW'(1) : n_q;
	assign rd_addr    = (state_q == ST_SCAN) ? scan_idx_q : emit_idx_q;
	assign last_idx   = IW'(n_q - CW'(1));

	// scan evaluation, one entry per cycle
	assign cand    = v_s1 && !done_q[idx_s1];
	assign arrived = TW'(rec_s1.arrival) <= time_q;
	assign better  = !have_q || (rec_s1.prio_level < best_prio_q) ||
		((rec_s1.prio_level == best_prio_q) && (rec_s1.arrival < best_arr_q));

	assign wait_x   = SW'(start_s1) - SW'(rec_s1.arrival);
	assign tat_x    = wait_x + SW'(rec_s1.burst);
	assign out_load = (state_q == ST_EMIT_OUT) && (!out_valid_q || out_ready);
	assign out_valid = out_valid_q;

	always_ff @(posedge clk) begin
		if (pop && beat.store) begin
			proc_mem[n_q[IW-1:0]] <= beat.rec;
		end
		if ((state_q == ST_SEL) && have_q) begin
			start_mem[best_idx_q] <= time_q;
		end
		rec_s1   <= proc_mem[rd_addr];
		start_s1 <= start_mem[emit_idx_q];
		idx_s1   <= scan_idx_q;
	end

	// result register, no reset on payload
	always_ff @(posedge clk) begin
		if (out_load) begin
			out_id           <= rec_s1.proc_id;
			start_time       <= nps_pkg::OUT_TIME_W'(start_s1);
			wait_time        <= wait_x[nps_pkg::OUT_TIME_W-1:0];
			turnaround       <= tat_x[nps_pkg::OUT_TAT_W-1:0];
			final_result     <= emit_idx_q == last_idx;
			if (emit_idx_q == last_idx) begin
				total_wait       <= sum_w_q + wait_x;
				total_turnaround <= sum_t_q + tat_x;
			end else begin
				total_wait       <= '0;
				total_turnaround <= '0;
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_IDLE;
			n_q         <= '0;
			left_q      <= '0;
			time_q      <= '0;
			done_q      <= '0;
			scan_idx_q  <= '0;
			emit_idx_q  <= '0;
			have_q      <= 1'b0;
			best_idx_q  <= '0;
			best_prio_q <= '0;
			best_arr_q  <= '0;
			best_run_q  <= '0;
			nxt_arr_q   <= '1;
			v_s1        <= 1'b0;
			sum_w_q     <= '0;
			sum_t_q     <= '0;
			out_valid_q <= 1'b0;
		end else begin
			v_s1 <= state_q == ST_SCAN;

			if (out_load) begin
				out_valid_q <= 1'b1;
			end else if (out_ready) begin
				out_valid_q <= 1'b0;
			end

			if (((state_q == ST_SCAN) || (state_q == ST_DRAIN)) && cand) begin
				if (rec_s1.arrival < nxt_arr_q) begin
					nxt_arr_q <= rec_s1.arrival;
				end
				if (arrived && better) begin
					have_q      <= 1'b1;
					best_idx_q  <= idx_s1;
					best_prio_q <= rec_s1.prio_level;
					best_arr_q  <= rec_s1.arrival;
					best_run_q  <= rec_s1.burst;
				end
			end

			case (state_q)
				ST_IDLE: begin
					if (pop) begin
						n_q <= n_new;
						if (beat.last) begin
							left_q     <= n_new;
							scan_idx_q <= '0;
							have_q     <= 1'b0;
							nxt_arr_q  <= '1;
							state_q    <= ST_SCAN;
						end
					end
				end
				ST_SCAN: begin
					scan_idx_q <= scan_idx_q + IW'(1);
					if (scan_idx_q == last_idx) begin
						state_q <= ST_DRAIN;
					end
				end
				ST_DRAIN: begin
					state_q <= ST_SEL;
				end
				ST_SEL: begin
					scan_idx_q <= '0;
					have_q     <= 1'b0;
					nxt_arr_q  <= '1;
					if (have_q) begin
						time_q             <= time_q + TW'(best_run_q);
						done_q[best_idx_q] <= 1'b1;
						left_q             <= left_q - CW'(1);
						if (left_q == CW'(1)) begin
							emit_idx_q <= '0;
							sum_w_q    <= '0;
							sum_t_q    <= '0;
							state_q    <= ST_EMIT_RD;
						end else begin
							state_q <= ST_SCAN;
						end
					end else begin
						// idle gap: jump to the earliest pending arrival
						time_q  <= TW'(nxt_arr_q);
						state_q <= ST_SCAN;
					end
				end
				ST_EMIT_RD: begin
					state_q <= ST_EMIT_OUT;
				end
				ST_EMIT_OUT: begin
					if (out_load) begin
						sum_w_q <= sum_w_q + wait_x;
						sum_t_q <= sum_t_q + tat_x;
						if (emit_idx_q == last_idx) begin
							n_q     <= '0;
							time_q  <= '0;
							done_q  <= '0;
							state_q <= ST_IDLE;
						end else begin
							emit_idx_q <= emit_idx_q + IW'(1);
							state_q    <= ST_EMIT_RD;
						end
					end
				end
				default: begin
					state_q <= ST_IDLE;
				end
			endcase
		end
	end

`ifndef NO_ASSERTIONS
	a_left_le_loaded: assert property (@(posedge clk) disable iff (!arst_n)
		left_q <= n_q)
		else $error("pending count exceeds loaded count");

	a_loaded_le_max: assert property (@(posedge clk) disable iff (!arst_n)
		n_q <= CW'(MAX_PROCS))
		else $error("loaded count beyond capacity");

	a_idle_no_pending: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_IDLE) |-> (left_q == '0))
		else $error("idle with unscheduled processes");

	a_jump_forward: assert property (@(posedge clk) disable iff (!arst_n)
		((state_q == ST_SEL) && !have_q) |-> (time_q < TW'(nxt_arr_q)))
		else $error("time jump does not move forward");

	a_emit_after_schedule: assert property (@(posedge clk) disable iff (!arst_n)
		out_load |-> (done_q[emit_idx_q] && (left_q == '0)))
		else $error("result emitted before schedule finished");
`endif

endmodule

`default_nettype wire

>>> rtl/core/nonpreemptive_priority_scheduler_top.sv
// ----------------------------------------------------------------------------
// nonpreemptive_priority_scheduler_top
// Non-preemptive priority scheduler over a table of loaded process records.
// ----------------------------------------------------------------------------
// Usage:
//   Input channel (in_valid/in_ready) takes one process record per beat.
//   Records fill a table of MAX_PROCS entries; records past capacity are
//   dropped. A beat with last_process set closes the load and starts the
//   schedule. Loading does not stall while the two-entry queue
//   and the back end have room.
//   Scheduling makes N selections (N = stored records); each selection is
//   a pass over the table, one entry per cycle through its single read
//   port, then the drain and select states; an idle gap adds one more
//   pass. Results then leave on the output channel (out_valid/out_ready),
//   one per stored record in load order, each read from the table and
//   then loaded into the result register; the last one carries
//   final_result and the totals.
//   A stalled receiver holds the result register; the back end waits and
//   the queue stops taking records once full.
//   Reset clears the table count, schedule time and finished flags.
// ----------------------------------------------------------------------------
`default_nettype none

module nonpreemptive_priority_scheduler_top #(
	parameter int unsigned MAX_PROCS = 16
) (
	input  wire         clk,
	input  wire         arst_n,
	input  wire         in_valid,
	output logic        in_ready,
	input  wire  [7:0]  proc_id,
	input  wire  [15:0] arrival,
	input  wire  [15:0] burst,
	input  wire  [7:0]  prio_level,
	input  wire         last_process,
	output logic        out_valid,
	input  wire         out_ready,
	output logic [7:0]  out_id,
	output logic [20:0] start_time,
	output logic [20:0] wait_time,
	output logic [21:0] turnaround,
	output logic [24:0] total_wait,
	output logic [24:0] total_turnaround,
	output logic        final_result
);

	logic                f_valid;
	logic                f_ready;
	nps_pkg::load_beat_t f_beat;
	logic                q_valid;
	logic                q_ready;
	nps_pkg::load_beat_t q_beat;

	nps_front #(
		.MAX_PROCS (MAX_PROCS)
	) u_front (
		.clk          (clk),
		.arst_n       (arst_n),
		.in_valid     (in_valid),
		.in_ready     (in_ready),
		.proc_id      (proc_id),
		.arrival      (arrival),
		.burst        (burst),
		.prio_level   (prio_level),
		.last_process (last_process),
		.beat_valid   (f_valid),
		.beat_ready   (f_ready),
		.beat         (f_beat)
	);

	nps_queue u_queue (
		.clk      (clk),
		.arst_n   (arst_n),
		.wr_valid (f_valid),
		.wr_ready (f_ready),
		.wr_beat  (f_beat),
		.rd_valid (q_valid),
		.rd_ready (q_ready),
		.rd_beat  (q_beat)
	);

	nps_back #(
		.MAX_PROCS (MAX_PROCS)
	) u_back (
		.clk              (clk),
		.arst_n           (arst_n),
		.beat_valid       (q_valid),
		.beat_ready       (q_ready),
		.beat             (q_beat),
		.out_valid        (out_valid),
		.out_ready        (out_ready),
		.out_id           (out_id),
		.start_time       (start_time),
		.wait_time        (wait_time),
		.turnaround       (turnaround),
		.total_wait       (total_wait),
		.total_turnaround (total_turnaround),
		.final_result     (final_result)
	);

endmodule

`default_nettype wire
